FILE: sv/glp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glp_pkg
// Shared types and constants of the grid line plotter.
// ----------------------------------------------------------------------------
package glp_pkg;

  localparam int MAX_SIDE_DEF = 128;
  localparam int COORD_W      = 7;
  localparam int SIDE_IN_W    = 8;
  localparam int NUM_W        = 2 * COORD_W;
  localparam int QUEUE_DEPTH  = 2;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_MOVE  = 2'd1,
    CMD_LINE  = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_RANGE  = 2'd1,
    ST_NOGRID = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    OP_CLEAR,
    OP_MARK,
    OP_LINE,
    OP_READ,
    OP_REJECT
  } op_kind_t;

  typedef struct packed {
    op_kind_t                   kind;
    status_t                    status;
    logic [SIDE_IN_W-1:0]       new_side;
    logic [COORD_W-1:0]         row;
    logic [COORD_W-1:0]         lo;
    logic [COORD_W-1:0]         hi;
    logic [COORD_W-1:0]         base;
    logic [COORD_W-1:0]         den;
    logic signed [COORD_W:0]    sdy;
  } op_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_CLR,
    BK_MK_RD,
    BK_MK_WR,
    BK_LN_INIT,
    BK_LN_RD,
    BK_LN_DIV,
    BK_LN_WR,
    BK_RD_REQ,
    BK_RD_GET,
    BK_RESP
  } bk_state_t;

endpackage

FILE: sv/glp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glp_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module glp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/glp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glp_front
// Accepts command words, checks them against grid state, emits ops.
// ----------------------------------------------------------------------------
module glp_front #(
  parameter int MAX_SIDE = glp_pkg::MAX_SIDE_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_cmd,
  input  logic [glp_pkg::COORD_W-1:0]    in_coord_x,
  input  logic [glp_pkg::COORD_W-1:0]    in_coord_y,
  input  logic [glp_pkg::SIDE_IN_W-1:0]  in_new_side,
  input  logic                           push_ready,
  output logic                           push_valid,
  output glp_pkg::op_t                   push_op
);

  localparam int SW = $clog2(MAX_SIDE + 1);
  localparam int CW = (SW > glp_pkg::SIDE_IN_W) ? SW : glp_pkg::SIDE_IN_W;
  localparam int AW = glp_pkg::COORD_W;

  logic [SW-1:0] side_r, side_nxt;
  logic          ready_r, ready_nxt;
  logic [AW-1:0] pen_x_r, pen_x_nxt;
  logic [AW-1:0] pen_y_r, pen_y_nxt;

  logic              accept;
  logic              outside;
  logic signed [AW:0] dx, dy;
  glp_pkg::op_t      op;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign accept     = in_valid && push_ready;
  assign push_op    = op;

  assign outside = (CW'(in_coord_x) >= CW'(side_r)) || (CW'(in_coord_y) >= CW'(side_r));
  assign dx      = $signed({1'b0, in_coord_x}) - $signed({1'b0, pen_x_r});
  assign dy      = $signed({1'b0, in_coord_y}) - $signed({1'b0, pen_y_r});

  always_comb begin
    op          = '0;
    op.kind     = glp_pkg::OP_REJECT;
    op.status   = glp_pkg::ST_DONE;
    op.new_side = in_new_side;
    op.row      = in_coord_x;
    op.lo       = in_coord_y;
    op.hi       = in_coord_y;
    if (in_cmd == glp_pkg::CMD_CLEAR) begin
      op.kind = glp_pkg::OP_CLEAR;
    end else if (!ready_r) begin
      op.status = glp_pkg::ST_NOGRID;
    end else if (outside) begin
      op.status = glp_pkg::ST_RANGE;
    end else begin
      case (in_cmd)
        glp_pkg::CMD_MOVE: begin
          op.kind = glp_pkg::OP_MARK;
        end
        glp_pkg::CMD_LINE: begin
          if (dx == '0) begin
            op.kind = glp_pkg::OP_MARK;
            op.lo   = (pen_y_r < in_coord_y) ? pen_y_r : in_coord_y;
            op.hi   = (pen_y_r < in_coord_y) ? in_coord_y : pen_y_r;
          end else begin
            op.kind = glp_pkg::OP_LINE;
            op.lo   = (pen_x_r < in_coord_x) ? pen_x_r : in_coord_x;
            op.hi   = (pen_x_r < in_coord_x) ? in_coord_x : pen_x_r;
            op.den  = dx[AW] ? AW'(-dx) : AW'(dx);
            op.sdy  = dx[AW] ? -dy : dy;
            op.base = dx[AW] ? in_coord_y : pen_y_r;
          end
        end
        glp_pkg::CMD_READ: begin
          op.kind = glp_pkg::OP_READ;
        end
        default: begin
          op.kind = glp_pkg::OP_REJECT;
        end
      endcase
    end
  end

  always_comb begin
    side_nxt  = side_r;
    ready_nxt = ready_r;
    pen_x_nxt = pen_x_r;
    pen_y_nxt = pen_y_r;
    if (accept) begin
      if (op.kind == glp_pkg::OP_CLEAR) begin
        ready_nxt = 1'b1;
        side_nxt  = (CW'(in_new_side) > CW'(MAX_SIDE)) ? SW'(MAX_SIDE) : SW'(in_new_side);
      end else if (op.kind == glp_pkg::OP_MARK || op.kind == glp_pkg::OP_LINE) begin
        pen_x_nxt = in_coord_x;
        pen_y_nxt = in_coord_y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r  <= '0;
      ready_r <= 1'b0;
      pen_x_r <= '0;
      pen_y_r <= '0;
    end else begin
      side_r  <= side_nxt;
      ready_r <= ready_nxt;
      pen_x_r <= pen_x_nxt;
      pen_y_r <= pen_y_nxt;
    end
  end

endmodule

FILE: sv/glp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glp_queue
// Short FIFO of ops between front and back.
// ----------------------------------------------------------------------------
module glp_queue (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  output logic         push_ready,
  input  glp_pkg::op_t push_op,
  output logic         pop_valid,
  input  logic         pop,
  output glp_pkg::op_t pop_op
);

  localparam int QD = glp_pkg::QUEUE_DEPTH;
  localparam int PW = (QD > 1) ? $clog2(QD) : 1;
  localparam int NW = $clog2(QD + 1);

  glp_pkg::op_t  q_r [QD];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign push_ready = (cnt_r != NW'(QD));
  assign pop_valid  = (cnt_r != '0);
  assign pop_op     = q_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QD - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QD - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

FILE: sv/glp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glp_back
// Executes ops on the row-organized grid RAM and registers results.
// ----------------------------------------------------------------------------
module glp_back #(
  parameter int MAX_SIDE = glp_pkg::MAX_SIDE_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         q_valid,
  input  glp_pkg::op_t q_op,
  output logic         q_pop,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [1:0]   out_status,
  output logic         out_cell_set
);

  localparam int SW = $clog2(MAX_SIDE + 1);
  localparam int CW = (SW > glp_pkg::SIDE_IN_W) ? SW : glp_pkg::SIDE_IN_W;
  localparam int RW = $clog2(MAX_SIDE);
  localparam int AW = glp_pkg::COORD_W;
  localparam int NW = glp_pkg::NUM_W;

  glp_pkg::bk_state_t state_r, state_nxt;
  glp_pkg::op_t       op_r, op_nxt;
  logic [SW-1:0]      side_r, side_nxt;
  logic [RW-1:0]      clr_cnt_r, clr_cnt_nxt;
  logic [AW-1:0]      row_r, row_nxt;
  logic [NW-1:0]      num_r, num_nxt;
  logic [NW-1:0]      rem_r, rem_nxt;
  logic [AW-1:0]      quo_r, quo_nxt;
  logic [2:0]         step_r, step_nxt;
  glp_pkg::status_t   res_status_r, res_status_nxt;
  logic               res_cell_r, res_cell_nxt;
  logic               out_valid_r, out_valid_nxt;
  glp_pkg::status_t   out_status_r, out_status_nxt;
  logic               out_cell_r, out_cell_nxt;

  logic                ram_we, ram_re;
  logic [RW-1:0]       ram_waddr, ram_raddr;
  logic [MAX_SIDE-1:0] ram_wdata, ram_rdata;
  logic [MAX_SIDE-1:0] mask;
  logic [AW-1:0]       mask_lo, mask_hi;
  logic [NW-1:0]       trial;
  logic [NW:0]         num_step;
  logic                row_in_grid;
  logic                out_load;

  glp_ram #(
    .WIDTH (MAX_SIDE),
    .DEPTH (MAX_SIDE)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_load    = (state_r == glp_pkg::BK_RESP) && (!out_valid_r || out_ready);
  assign row_in_grid = (CW'(row_r) < CW'(side_r));
  assign trial       = NW'({{(NW - AW){1'b0}}, op_r.den} << step_r);
  assign num_step    = {1'b0, num_r} + {{(NW - AW){op_r.sdy[AW]}}, op_r.sdy};
  assign mask_lo     = (state_r == glp_pkg::BK_LN_WR) ? quo_r : op_r.lo;
  assign mask_hi     = (state_r == glp_pkg::BK_LN_WR) ? quo_r : op_r.hi;

  always_comb begin
    for (int i = 0; i < MAX_SIDE; i++) begin
      mask[i] = (CW'(i) >= CW'(mask_lo)) && (CW'(i) <= CW'(mask_hi)) &&
                (CW'(i) < CW'(side_r));
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      glp_pkg::BK_IDLE: begin
        if (q_valid) begin
          case (q_op.kind)
            glp_pkg::OP_CLEAR: state_nxt = glp_pkg::BK_CLR;
            glp_pkg::OP_MARK:  state_nxt = glp_pkg::BK_MK_RD;
            glp_pkg::OP_LINE:  state_nxt = glp_pkg::BK_LN_INIT;
            glp_pkg::OP_READ:  state_nxt = glp_pkg::BK_RD_REQ;
            default:           state_nxt = glp_pkg::BK_RESP;
          endcase
        end
      end
      glp_pkg::BK_CLR: begin
        if (clr_cnt_r == RW'(MAX_SIDE - 1)) begin
          state_nxt = glp_pkg::BK_RESP;
        end
      end
      glp_pkg::BK_MK_RD:   state_nxt = glp_pkg::BK_MK_WR;
      glp_pkg::BK_MK_WR:   state_nxt = glp_pkg::BK_RESP;
      glp_pkg::BK_LN_INIT: state_nxt = glp_pkg::BK_LN_RD;
      glp_pkg::BK_LN_RD:   state_nxt = glp_pkg::BK_LN_DIV;
      glp_pkg::BK_LN_DIV: begin
        if (step_r == '0) begin
          state_nxt = glp_pkg::BK_LN_WR;
        end
      end
      glp_pkg::BK_LN_WR: begin
        state_nxt = (row_r == op_r.hi) ? glp_pkg::BK_RESP : glp_pkg::BK_LN_RD;
      end
      glp_pkg::BK_RD_REQ:  state_nxt = glp_pkg::BK_RD_GET;
      glp_pkg::BK_RD_GET:  state_nxt = glp_pkg::BK_RESP;
      glp_pkg::BK_RESP: begin
        if (out_load) begin
          state_nxt = glp_pkg::BK_IDLE;
        end
      end
      default: state_nxt = glp_pkg::BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop     = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = RW'(op_r.row);
    ram_wdata = ram_rdata | mask;
    ram_re    = 1'b0;
    ram_raddr = RW'(op_r.row);
    case (state_r)
      glp_pkg::BK_IDLE: q_pop = q_valid;
      glp_pkg::BK_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_r;
        ram_wdata = '0;
      end
      glp_pkg::BK_MK_RD:  ram_re = 1'b1;
      glp_pkg::BK_MK_WR:  ram_we = 1'b1;
      glp_pkg::BK_LN_RD: begin
        ram_re    = 1'b1;
        ram_raddr = RW'(row_r);
      end
      glp_pkg::BK_LN_WR: begin
        ram_we    = row_in_grid;
        ram_waddr = RW'(row_r);
      end
      glp_pkg::BK_RD_REQ: ram_re = 1'b1;
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  // datapath
  always_comb begin
    op_nxt         = op_r;
    side_nxt       = side_r;
    clr_cnt_nxt    = clr_cnt_r;
    row_nxt        = row_r;
    num_nxt        = num_r;
    rem_nxt        = rem_r;
    quo_nxt        = quo_r;
    step_nxt       = step_r;
    res_status_nxt = res_status_r;
    res_cell_nxt   = res_cell_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_cell_nxt   = out_cell_r;
    case (state_r)
      glp_pkg::BK_IDLE: begin
        if (q_valid) begin
          op_nxt         = q_op;
          clr_cnt_nxt    = '0;
          res_cell_nxt   = 1'b0;
          res_status_nxt = (q_op.kind == glp_pkg::OP_REJECT) ? q_op.status : glp_pkg::ST_DONE;
          if (q_op.kind == glp_pkg::OP_CLEAR) begin
            side_nxt = (CW'(q_op.new_side) > CW'(MAX_SIDE)) ? SW'(MAX_SIDE) :
                       SW'(q_op.new_side);
          end
        end
      end
      glp_pkg::BK_CLR: clr_cnt_nxt = clr_cnt_r + 1'b1;
      glp_pkg::BK_LN_INIT: begin
        num_nxt = NW'(op_r.base) * NW'(op_r.den);
        row_nxt = op_r.lo;
      end
      glp_pkg::BK_LN_RD: begin
        rem_nxt  = num_r;
        quo_nxt  = '0;
        step_nxt = 3'(AW - 1);
      end
      glp_pkg::BK_LN_DIV: begin
        if (rem_r >= trial) begin
          rem_nxt         = rem_r - trial;
          quo_nxt[step_r] = 1'b1;
        end
        step_nxt = step_r - 1'b1;
      end
      glp_pkg::BK_LN_WR: begin
        row_nxt = row_r + 1'b1;
        num_nxt = num_step[NW-1:0];
      end
      glp_pkg::BK_RD_GET: res_cell_nxt = ram_rdata[RW'(op_r.lo)];
      default: begin
        res_cell_nxt = res_cell_r;
      end
    endcase
    if (out_load) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = res_status_r;
      out_cell_nxt   = res_cell_r;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= glp_pkg::BK_IDLE;
      side_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      side_r      <= side_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    clr_cnt_r    <= clr_cnt_nxt;
    row_r        <= row_nxt;
    num_r        <= num_nxt;
    rem_r        <= rem_nxt;
    quo_r        <= quo_nxt;
    step_r       <= step_nxt;
    res_status_r <= res_status_nxt;
    res_cell_r   <= res_cell_nxt;
    out_status_r <= out_status_nxt;
    out_cell_r   <= out_cell_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_cell_set = out_cell_r;

endmodule

FILE: sv/grid_line_plotter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_line_plotter
// Pen plotter over a square bit grid: clear, move, line and read commands.
// ----------------------------------------------------------------------------
//  channel | dir | handshake           | word
//  in_     | in  | in_valid/in_ready   | cmd, coord_x, coord_y, new_side
//  out_    | out | out_valid/out_ready | status, cell_set
//
//  A clear writes every grid row; a line walks its rows one by one, each row
//  with one RAM read, a 7-step restoring divider and one RAM write.
//  Front checks words into a 2-deep op queue; the back drains it one op at
//  a time, so the input stalls only when the queue is full.
//  Reset clears control state only; the grid RAM is swept by the first clear,
//  and every other command is rejected before it.
// ----------------------------------------------------------------------------
module grid_line_plotter #(
  parameter int MAX_SIDE = glp_pkg::MAX_SIDE_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_cmd,
  input  logic [glp_pkg::COORD_W-1:0]   in_coord_x,
  input  logic [glp_pkg::COORD_W-1:0]   in_coord_y,
  input  logic [glp_pkg::SIDE_IN_W-1:0] in_new_side,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_status,
  output logic                          out_cell_set
);

  logic         push_valid, push_ready;
  glp_pkg::op_t push_op;
  logic         pop_valid, pop;
  glp_pkg::op_t pop_op;

  glp_front #(
    .MAX_SIDE (MAX_SIDE)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_cmd      (in_cmd),
    .in_coord_x  (in_coord_x),
    .in_coord_y  (in_coord_y),
    .in_new_side (in_new_side),
    .push_ready  (push_ready),
    .push_valid  (push_valid),
    .push_op     (push_op)
  );

  glp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_op     (pop_op)
  );

  glp_back #(
    .MAX_SIDE (MAX_SIDE)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (pop_valid),
    .q_op         (pop_op),
    .q_pop        (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .out_cell_set (out_cell_set)
  );

endmodule
